@@ rtl/core/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and helpers for the instruction subset execute block:
// opcodes, error codes, memory geometry and program counter wrapping.
// ----------------------------------------------------------------------------
package mse_pkg;

    // memory geometry
    localparam int DATA_DEPTH    = 1024;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int DADDR_W       = $clog2(DATA_DEPTH);

    localparam logic [32:0] DATA_DEPTH_33 = 33'(DATA_DEPTH);
    localparam logic [20:0] PC_DEPTH_21   = 21'(PROGRAM_DEPTH);
    localparam logic [16:0] PC_DEPTH_17   = 17'(PROGRAM_DEPTH);
    localparam logic [10:0] PC_DEPTH_11   = 11'(PROGRAM_DEPTH);

    // reciprocal for the branch target wrap, exact for 10-bit targets
    localparam int          PC_RECIP_SHIFT = 24;
    localparam logic [30:0] PC_RECIP =
        31'(((2 ** PC_RECIP_SHIFT) + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH);

    // opcodes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_SLT  = 4'd3;
    localparam logic [3:0] OP_ADDI = 4'd4;
    localparam logic [3:0] OP_BEQ  = 4'd5;
    localparam logic [3:0] OP_BNE  = 4'd6;
    localparam logic [3:0] OP_J    = 4'd7;
    localparam logic [3:0] OP_LW   = 4'd8;
    localparam logic [3:0] OP_SW   = 4'd9;

    // error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_REGZERO = 2'd1;
    localparam logic [1:0] ERR_OPCODE  = 2'd2;
    localparam logic [1:0] ERR_ADDR    = 2'd3;

    // branch target modulo the program depth
    function automatic logic [9:0] pc_wrap(input logic [9:0] target);
        logic [30:0] prod;
        logic [6:0]  quo;
        logic [16:0] qpd;
        logic [10:0] rem;
        prod = 31'(target) * PC_RECIP;
        quo  = prod[PC_RECIP_SHIFT+6:PC_RECIP_SHIFT];
        qpd  = 17'(quo) * PC_DEPTH_17;
        rem  = 11'(17'(target) - qpd);
        if (rem >= PC_DEPTH_11) begin
            rem = rem - PC_DEPTH_11;
        end
        if (PROGRAM_DEPTH > 1023) begin
            return target;
        end
        return rem[9:0];
    endfunction

endpackage

@@ rtl/core/mips_subset_execute.sv @@
// ----------------------------------------------------------------------------
// mips_subset_execute
// Executes one decoded instruction per input word against a register file,
// a word-addressed data memory and a program counter; one result per word.
// ----------------------------------------------------------------------------
// path: register file read at accept, execute, then the output register
// (for lw, the data memory read in the load stage lies between execute and output)
// throughput: one word per cycle while the output is taken; the word behind a lw waits in
// execute while the load stage retires
// reset: control clears at once; then a clearing pass zeroes the data memory word
// by word, during which s_ready stays low
module mips_subset_execute (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_operation,
    input  logic [4:0]  s_dest_reg,
    input  logic [4:0]  s_src_reg,
    input  logic [4:0]  s_second_reg,
    input  logic signed [15:0] s_immediate,
    input  logic [9:0]  s_branch_target,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_next_pc,
    output logic        m_reg_write_enable,
    output logic [4:0]  m_reg_write_index,
    output logic signed [31:0] m_reg_write_value,
    output logic [1:0]  m_error_code
);
    import mse_pkg::*;

    // storage
    logic [31:0] rf_mem [32];
    logic [31:0] dmem [DATA_DEPTH];
    logic [31:0] rf_valid_reg;
    logic [9:0]  pc_reg;
    logic [9:0]  pc_next;

    // clearing pass
    logic               clr_active_reg;
    logic [DADDR_W-1:0] clr_addr_reg;

    // execute stage
    logic        x_valid_reg;
    logic [3:0]  x_op_reg;
    logic [4:0]  x_rd_reg;
    logic [4:0]  x_rs_reg;
    logic [4:0]  x_rb_reg;
    logic [15:0] x_imm_reg;
    logic [9:0]  x_tgt_reg;
    logic [31:0] rfa_data_reg;
    logic [31:0] rfb_data_reg;
    logic        rfa_vld_reg;
    logic        rfb_vld_reg;

    // last register write, for forwarding
    logic        fwd_valid_reg;
    logic [4:0]  fwd_idx_reg;
    logic [31:0] fwd_val_reg;

    // load stage
    logic        ld_valid_reg;
    logic [4:0]  ld_rd_reg;
    logic [9:0]  ld_npc_reg;
    logic [31:0] dmem_rdata_reg;

    // output register
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [9:0]  out_npc_reg;
    logic        out_we_reg;
    logic [4:0]  out_idx_reg;
    logic [31:0] out_val_reg;
    logic [1:0]  out_err_reg;

    logic [4:0]  rb_sel;
    logic        s_accept;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [32:0] addr_sum;
    logic [DADDR_W-1:0] x_addr;
    logic [9:0]  seq_pc;
    logic [10:0] seq_sum;
    logic [9:0]  x_npc;
    logic        x_we;
    logic [31:0] x_val;
    logic [1:0]  x_err;
    logic        x_is_load;
    logic        x_is_store;
    logic        out_free;
    logic        ld_done;
    logic        x_complete;
    logic        x_to_load;
    logic        x_done;
    logic        rf_we;
    logic [4:0]  rf_widx;
    logic [31:0] rf_wval;
    logic        out_load;

    // handshake
    assign out_free   = !m_valid_reg || m_ready;
    assign ld_done    = ld_valid_reg && out_free;
    assign x_complete = x_valid_reg && !x_is_load && !ld_valid_reg && out_free;
    assign x_to_load  = x_valid_reg && x_is_load && !ld_valid_reg;
    assign x_done     = x_complete || x_to_load;
    assign s_ready    = !clr_active_reg && (!x_valid_reg || x_done);
    assign s_accept   = s_valid && s_ready;
    assign out_load   = ld_done || x_complete;

    // port b reads the store data register for sw
    assign rb_sel = (s_operation == OP_SW) ? s_dest_reg : s_second_reg;

    // operands with forwarding of the most recent register write
    always_comb begin
        if (fwd_valid_reg && fwd_idx_reg == x_rs_reg) begin
            op_a = fwd_val_reg;
        end else begin
            op_a = rfa_vld_reg ? rfa_data_reg : 32'd0;
        end
        if (fwd_valid_reg && fwd_idx_reg == x_rb_reg) begin
            op_b = fwd_val_reg;
        end else begin
            op_b = rfb_vld_reg ? rfb_data_reg : 32'd0;
        end
    end

    // sequential pc and memory address
    assign seq_sum  = {1'b0, pc_reg} + 11'd1;
    assign seq_pc   = ({10'd0, seq_sum} == PC_DEPTH_21) ? 10'd0 : seq_sum[9:0];
    assign addr_sum = {op_a[31], op_a} + {{17{x_imm_reg[15]}}, x_imm_reg};
    assign x_addr   = addr_sum[DADDR_W-1:0];

    // execute
    always_comb begin
        x_npc      = seq_pc;
        x_we       = 1'b0;
        x_val      = 32'd0;
        x_err      = ERR_OK;
        x_is_load  = 1'b0;
        x_is_store = 1'b0;
        unique case (x_op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI: begin
                if (x_rd_reg == 5'd0) begin
                    x_err = ERR_REGZERO;
                end else begin
                    x_we = 1'b1;
                    unique case (x_op_reg)
                        OP_ADD:  x_val = op_a + op_b;
                        OP_SUB:  x_val = op_a - op_b;
                        OP_MUL:  x_val = op_a * op_b;
                        OP_SLT:  x_val = {31'd0, $signed(op_a) < $signed(op_b)};
                        default: x_val = op_a + {{16{x_imm_reg[15]}}, x_imm_reg};
                    endcase
                end
            end
            OP_BEQ: begin
                if (op_a == op_b) begin
                    x_npc = pc_wrap(x_tgt_reg);
                end
            end
            OP_BNE: begin
                if (op_a != op_b) begin
                    x_npc = pc_wrap(x_tgt_reg);
                end
            end
            OP_J: begin
                x_npc = pc_wrap(x_tgt_reg);
            end
            OP_LW, OP_SW: begin
                if (x_op_reg == OP_LW && x_rd_reg == 5'd0) begin
                    x_err = ERR_REGZERO;
                end else if (addr_sum[32] || addr_sum >= DATA_DEPTH_33) begin
                    x_err = ERR_ADDR;
                end else if (x_op_reg == OP_LW) begin
                    x_is_load = 1'b1;
                end else begin
                    x_is_store = 1'b1;
                end
            end
            default: begin
                x_err = ERR_OPCODE;
            end
        endcase
        if (x_err != ERR_OK) begin
            x_npc = pc_reg;
            x_we  = 1'b0;
            x_val = 32'd0;
        end
    end

    // register write select: load stage or execute stage, never both
    assign rf_we   = (x_complete && x_we) || ld_done;
    assign rf_widx = ld_done ? ld_rd_reg : x_rd_reg;
    assign rf_wval = ld_done ? dmem_rdata_reg : x_val;

    assign pc_next      = x_done ? x_npc : pc_reg;
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            rf_valid_reg   <= 32'd0;
            pc_reg         <= 10'd0;
            x_valid_reg    <= 1'b0;
            ld_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == DADDR_W'(DATA_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (rf_we) begin
                rf_valid_reg[rf_widx] <= 1'b1;
                fwd_valid_reg         <= 1'b1;
            end
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                x_valid_reg <= 1'b1;
            end else if (x_done) begin
                x_valid_reg <= 1'b0;
            end
            if (x_to_load) begin
                ld_valid_reg <= 1'b1;
            end else if (ld_done) begin
                ld_valid_reg <= 1'b0;
            end
        end
    end

    // register file with registered read ports
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_widx] <= rf_wval;
            fwd_idx_reg     <= rf_widx;
            fwd_val_reg     <= rf_wval;
        end
        if (s_accept) begin
            rfa_data_reg <= rf_mem[s_src_reg];
            rfb_data_reg <= rf_mem[rb_sel];
            rfa_vld_reg  <= rf_valid_reg[s_src_reg];
            rfb_vld_reg  <= rf_valid_reg[rb_sel];
            x_op_reg     <= s_operation;
            x_rd_reg     <= s_dest_reg;
            x_rs_reg     <= s_src_reg;
            x_rb_reg     <= rb_sel;
            x_imm_reg    <= s_immediate;
            x_tgt_reg    <= s_branch_target;
        end
    end

    // data memory: clearing pass, stores and load reads
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            dmem[clr_addr_reg] <= 32'd0;
        end else if (x_complete && x_is_store) begin
            dmem[x_addr] <= op_b;
        end
        if (x_to_load) begin
            dmem_rdata_reg <= dmem[x_addr];
            ld_rd_reg      <= x_rd_reg;
            ld_npc_reg     <= x_npc;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (ld_done) begin
            out_npc_reg <= ld_npc_reg;
            out_we_reg  <= 1'b1;
            out_idx_reg <= ld_rd_reg;
            out_val_reg <= dmem_rdata_reg;
            out_err_reg <= ERR_OK;
        end else if (x_complete) begin
            out_npc_reg <= x_npc;
            out_we_reg  <= x_we;
            out_idx_reg <= x_we ? x_rd_reg : 5'd0;
            out_val_reg <= x_val;
            out_err_reg <= x_err;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_next_pc          = out_npc_reg;
    assign m_reg_write_enable = out_we_reg;
    assign m_reg_write_index  = out_idx_reg;
    assign m_reg_write_value  = out_val_reg;
    assign m_error_code       = out_err_reg;

    // checks
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("input accepted during data memory clearing");

    a_single_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        !(x_complete && ld_done))
        else $error("execute and load stages retired together");

    a_reg_zero_unwritten: assert property (@(posedge aclk) disable iff (!aresetn)
        !rf_valid_reg[0])
        else $error("register zero was written");

    a_error_keeps_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (x_complete && x_err != ERR_OK) |=> (pc_reg == $past(pc_reg)))
        else $error("program counter moved on an error");

endmodule
